>>> rtl/pfd_pkg.sv
// Shared types and constants for the packet frame decoder.
// Used by pfd_frame_parse and packet_frame_decoder; no dependencies.
`default_nettype none

package pfd_pkg;

	// Frame layout: byte 8 holds the payload length, the payload starts at byte 9.
	localparam int unsigned POS_W   = 9;
	localparam int unsigned LEN_POS = 8;
	localparam int unsigned HDR_LEN = 9;
	// Last position covered by the checksum is length plus this offset, minus one.
	localparam int unsigned SUM_END = 8;
	// Checksum byte sits at length + HDR_LEN, end marker one after it.
	localparam int unsigned END_OFS = 10;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_START  = 3'd1,
		ST_BAD_SECOND = 3'd2,
		ST_BROADCAST  = 3'd3,
		ST_BAD_END    = 3'd4,
		ST_CHECKSUM   = 3'd5,
		ST_TRUNCATED  = 3'd6
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CFG_START_BYTE     = 2'd0,
		CFG_END_BYTE       = 2'd1,
		CFG_BROADCAST_NODE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		kind_t      out_kind;
		logic [7:0] payload_byte;
		status_t    status;
		logic [7:0] sender_id;
		logic [7:0] target_id;
		logic [7:0] message_type;
		logic [7:0] data_type;
		logic       ack_wanted;
		logic [7:0] sequence_count;
		logic [7:0] payload_length;
	} out_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] broadcast_node;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/pfd_frame_parse.sv
// Frame walker: per-frame state and the one-byte update step.
// Depends on pfd_pkg.
`default_nettype none

module pfd_frame_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire pfd_pkg::in_t  byte_in,
	input  wire pfd_pkg::cfg_t cfg,
	output logic               res_valid,
	output pfd_pkg::out_t      res
);

	typedef struct packed {
		logic [pfd_pkg::POS_W-1:0] pos;
		logic [7:0]                sum;
		pfd_pkg::status_t          err;
		logic [7:0]                sender;
		logic [7:0]                target;
		logic [7:0]                mtype;
		logic [7:0]                dtype;
		logic                      ack;
		logic [7:0]                seq;
		logic [7:0]                len;
		logic [7:0]                csum;
		logic                      done;
	} frame_t;

	frame_t                    cur_q;
	frame_t                    upd;
	frame_t                    nxt;
	logic [7:0]                b;
	logic                      last;
	logic [pfd_pkg::POS_W-1:0] pay_end;
	logic [pfd_pkg::POS_W-1:0] sum_end;
	logic                      end_hit;
	logic                      pay_hit;
	logic                      verdict;
	pfd_pkg::status_t          vstatus;

	assign b       = byte_in.data_byte;
	assign last    = byte_in.frame_end;
	assign pay_end = {1'b0, cur_q.len} + pfd_pkg::POS_W'(pfd_pkg::HDR_LEN);
	assign sum_end = {1'b0, cur_q.len} + pfd_pkg::POS_W'(pfd_pkg::SUM_END);

	always_comb begin
		upd     = cur_q;
		end_hit = 1'b0;
		pay_hit = 1'b0;
		vstatus = pfd_pkg::ST_OK;
		if (!cur_q.done) begin
			if (cur_q.pos <= pfd_pkg::POS_W'(pfd_pkg::LEN_POS) || cur_q.pos < sum_end) begin
				upd.sum = cur_q.sum + b;
			end
			case (cur_q.pos)
				9'd0: begin
					if (b != cfg.start_byte && cur_q.err == pfd_pkg::ST_OK) begin
						upd.err = pfd_pkg::ST_BAD_START;
					end
				end
				9'd1: begin
					if (b != 8'd0 && cur_q.err == pfd_pkg::ST_OK) begin
						upd.err = pfd_pkg::ST_BAD_SECOND;
					end
				end
				9'd2: begin
					upd.sender = b;
					if (b == cfg.broadcast_node && cur_q.err == pfd_pkg::ST_OK) begin
						upd.err = pfd_pkg::ST_BROADCAST;
					end
				end
				9'd3: upd.target = b;
				9'd4: upd.mtype  = b;
				9'd5: upd.dtype  = b;
				9'd6: upd.ack    = (b != 8'd0);
				9'd7: upd.seq    = b;
				9'd8: upd.len    = b;
				default: begin
					if (cur_q.pos < pay_end) begin
						pay_hit = 1'b1;
					end else if (cur_q.pos == pay_end) begin
						upd.csum = b;
					end else begin
						end_hit = 1'b1;
						if (cur_q.err != pfd_pkg::ST_OK) begin
							vstatus = cur_q.err;
						end else if (b != cfg.end_byte) begin
							vstatus = pfd_pkg::ST_BAD_END;
						end else if (cur_q.sum != cur_q.csum) begin
							vstatus = pfd_pkg::ST_CHECKSUM;
						end else begin
							vstatus = pfd_pkg::ST_OK;
						end
					end
				end
			endcase
			if (end_hit) begin
				upd.done = 1'b1;
			end else begin
				upd.pos = cur_q.pos + 1'b1;
			end
			// an early buffer end turns into a verdict of its own
			if (last && !end_hit) begin
				vstatus = (upd.err != pfd_pkg::ST_OK) ? upd.err : pfd_pkg::ST_TRUNCATED;
			end
		end
	end

	assign verdict = !cur_q.done && (end_hit || last);

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (verdict) begin
			res_valid          = 1'b1;
			res.out_kind       = pfd_pkg::KIND_VERDICT;
			res.status         = vstatus;
			res.sender_id      = upd.sender;
			res.target_id      = upd.target;
			res.message_type   = upd.mtype;
			res.data_type      = upd.dtype;
			res.ack_wanted     = upd.ack;
			res.sequence_count = upd.seq;
			res.payload_length = upd.len;
		end else if (!cur_q.done && pay_hit) begin
			res_valid        = 1'b1;
			res.out_kind     = pfd_pkg::KIND_PAYLOAD;
			res.payload_byte = b;
		end
	end

	// any flagged byte drops the whole frame state
	assign nxt = last ? '0 : upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

endmodule

`default_nettype wire

>>> rtl/packet_frame_decoder.sv
// Top level of the packet frame decoder: channels, input and result registers.
// Depends on pfd_pkg and pfd_frame_parse.
// Usage:
//   byte channel   (byte_valid/byte_ready/byte_data) carries one frame byte per
//                  beat, with frame_end set on the last byte of the link buffer.
//   result channel (result_valid/result_ready/result_data) carries either a
//                  payload byte (out_kind 0) or a frame verdict (out_kind 1)
//                  with the header fields and the first error seen.
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data) writes start_byte,
//                  end_byte and broadcast_node; cfg_ready is always high and
//                  writes to an index past the list are dropped. Write only
//                  while no byte is in flight.
// Timing: an accepted byte waits in the input register, is parsed there by
//   combinational logic, and its result beat, if any, is loaded into the
//   result register when the byte advances. Throughput is one byte per cycle
//   while results are taken, set by the combinational parse step in between.
// Stall: while a result waits on result_ready, one more byte is held in the
//   input register; byte_ready drops only when both are full.
// Reset: arst_n clears the frame state, both valid flags and the registers
//   (start_byte 0, end_byte 0, broadcast_node 255).
`default_nettype none

module packet_frame_decoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire pfd_pkg::in_t  byte_data,
	output logic               result_valid,
	input  wire logic          result_ready,
	output pfd_pkg::out_t      result_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data
);

	pfd_pkg::cfg_t  cfg_q;
	pfd_pkg::in_t   byte_s1;
	logic           valid_s1;
	logic           advance;
	logic           res_valid;
	pfd_pkg::out_t  res;
	logic           res_valid_q;
	pfd_pkg::out_t  res_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte     <= 8'd0;
			cfg_q.end_byte       <= 8'd0;
			cfg_q.broadcast_node <= 8'hFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfd_pkg::CFG_START_BYTE:     cfg_q.start_byte     <= cfg_data;
				pfd_pkg::CFG_END_BYTE:       cfg_q.end_byte       <= cfg_data;
				pfd_pkg::CFG_BROADCAST_NODE: cfg_q.broadcast_node <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the held byte whenever the result slot is free or being drained.
	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_data;
		end
	end

	pfd_frame_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register: load a new beat, or drop the old one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> valid_s1 && res_valid_q && !result_ready)
		else $error("byte_ready low with a free slot");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.out_kind == pfd_pkg::KIND_PAYLOAD |->
		result_data.status == pfd_pkg::ST_OK && result_data.sender_id == 8'd0 &&
		result_data.payload_length == 8'd0)
		else $error("payload beat carries verdict fields");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(advance))
		else $error("result beat appeared without a parse step");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.status <= pfd_pkg::ST_TRUNCATED)
		else $error("result status out of range");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for packet_frame_decoder: byte, result and register channels.
// Depends on pfd_pkg and the decoder RTL; predicts every result beat in-line.
`timescale 1ns / 1ps

module tb;
	import pfd_pkg::*;

	// Write to this register index is dropped by the block.
	localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 200;
	localparam int PHASES      = 6;
	localparam int PHASE_BYTES = 60;
	localparam int PRINT_CAP   = 100;

	// Ways a generated frame is damaged before it is sent.
	typedef enum int {
		FLAW_NONE, FLAW_START, FLAW_SECOND, FLAW_SENDER,
		FLAW_SUM, FLAW_END, FLAW_CUT, FLAW_NOISE
	} flaw_t;

	// Directed row: one byte, and where pinned, the verdict status typed in by hand.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pinned;
		status_t    verdict;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	// Clean frame at reset settings, length 1, extreme header values, trailing byte
	// after the end marker; then a frame with bad start, bad second and broadcast
	// sender whose payload is still passed and whose flagged payload byte is not;
	// then a one-byte buffer that ends the frame early.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'h80, 1'b0, 1'b0, ST_OK},
		'{8'h7F, 1'b0, 1'b0, ST_OK},
		'{8'h80, 1'b0, 1'b0, ST_OK},
		'{8'hFE, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'h7E, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b1, ST_OK},
		'{8'h5A, 1'b1, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h02, 1'b0, 1'b0, ST_OK},
		'{8'h11, 1'b0, 1'b0, ST_OK},
		'{8'h22, 1'b1, 1'b1, ST_BAD_START},
		'{8'h00, 1'b1, 1'b1, ST_TRUNCATED}
	};

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic       byte_ready;
	in_t        byte_data    = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_t       result_data;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index    = '0;
	logic [7:0] cfg_data     = '0;

	packet_frame_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Predicted decoder state: register copy and the frame being walked.
	cfg_t       regs;
	logic [8:0] fr_pos;
	logic [7:0] fr_sum;
	status_t    fr_err;
	out_t       fr_hdr;     // header fields only; kind and status stay zero
	logic [7:0] fr_csum;
	logic       fr_done;

	out_t pending_results [$];

	// Idling controls for the stimulus and the result sink.
	int byte_gap     = 0;
	bit byte_hold    = 1'b0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;
	bit rx_long_hold = 1'b0;

	int mismatches    = 0;
	int beat_no       = 0;
	int bytes_taken   = 0;
	int payload_cnt   = 0;
	int settings_used = 1;
	int verdict_cnt [8];
	int cycle_cnt     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Kill a hung run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				pending_results.size());
			$display("FAIL packet_frame_decoder");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("ERROR %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void clear_frame();
		fr_pos  = '0;
		fr_sum  = '0;
		fr_err  = ST_OK;
		fr_hdr  = '0;
		fr_csum = '0;
		fr_done = 1'b0;
	endfunction

	// Keep only the first of the start, second-byte and sender errors.
	function automatic void note_error(input status_t code);
		if (fr_err == ST_OK)
			fr_err = code;
	endfunction

	// Advance the predicted frame by one accepted byte; return 1 with the beat it causes.
	function automatic bit decode_byte(input in_t b, output out_t r);
		logic [7:0] d;
		int         p;
		int         len;
		bit         verdict_due;
		bit         payload_due;
		status_t    v;
		d           = b.data_byte;
		p           = fr_pos;
		len         = fr_hdr.payload_length;
		verdict_due = 1'b0;
		payload_due = 1'b0;
		v           = ST_OK;
		r           = '0;
		// After the verdict, swallow bytes until the buffer ends.
		if (fr_done) begin
			if (b.frame_end)
				clear_frame();
			return 1'b0;
		end
		bytes_taken++;
		// Sum covers bytes 0 through len+7; a zero length byte adds nothing anyway.
		if (p <= LEN_POS || p <= len + SUM_END - 1)
			fr_sum += d;
		if (p == 0) begin
			if (d != regs.start_byte)
				note_error(ST_BAD_START);
		end else if (p == 1) begin
			if (d != 8'h00)
				note_error(ST_BAD_SECOND);
		end else if (p == 2) begin
			fr_hdr.sender_id = d;
			if (d == regs.broadcast_node)
				note_error(ST_BROADCAST);
		end else if (p < HDR_LEN) begin
			case (p)
				3: fr_hdr.target_id = d;
				4: fr_hdr.message_type = d;
				5: fr_hdr.data_type = d;
				6: fr_hdr.ack_wanted = (d != 8'h00);
				7: fr_hdr.sequence_count = d;
				default: fr_hdr.payload_length = d;
			endcase
		end else if (p < HDR_LEN + len) begin
			payload_due = 1'b1;
		end else if (p == HDR_LEN + len) begin
			fr_csum = d;
		end else begin
			// End marker: stored error, then bad marker, then checksum.
			if (fr_err != ST_OK)
				v = fr_err;
			else if (d != regs.end_byte)
				v = ST_BAD_END;
			else if (fr_sum != fr_csum)
				v = ST_CHECKSUM;
			else
				v = ST_OK;
			verdict_due = 1'b1;
			fr_done     = 1'b1;
		end
		if (!fr_done)
			fr_pos = fr_pos + 1'b1;
		// Buffer ended before the end marker.
		if (b.frame_end && !verdict_due) begin
			v           = (fr_err != ST_OK) ? fr_err : ST_TRUNCATED;
			verdict_due = 1'b1;
		end
		if (verdict_due) begin
			r          = fr_hdr;
			r.out_kind = KIND_VERDICT;
			r.status   = v;
			if (b.frame_end)
				clear_frame();
			return 1'b1;
		end
		if (payload_due) begin
			r.out_kind     = KIND_PAYLOAD;
			r.payload_byte = d;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offer one byte, hold it until taken, then record what it should cause.
	task automatic send_byte(input in_t b, input bit pinned, input status_t pin_st);
		out_t r;
		if (!byte_hold)
			repeat (byte_gap) @(posedge clk);
		byte_valid <= 1'b1;
		byte_data  <= b;
		do @(posedge clk); while (!byte_ready);
		if (decode_byte(b, r)) begin
			if (pinned) begin
				r.out_kind = KIND_VERDICT;
				r.status   = pin_st;
			end
			pending_results.push_back(r);
		end else if (pinned) begin
			report_mismatch("directed row pins a verdict that the byte cannot cause");
		end
		// Draw the gap before the next beat; leave valid high when there is none.
		byte_gap  = tx_burst ? 0 : $urandom_range(0, 12);
		byte_hold = (byte_gap == 0);
		if (!byte_hold)
			byte_valid <= 1'b0;
	endtask

	// Drop valid when the sender is about to pause.
	task automatic release_bytes();
		if (byte_hold) begin
			byte_valid <= 1'b0;
			byte_hold  = 1'b0;
		end
	endtask

	// Stop sending until every expected beat is back, then let the block settle.
	task automatic wait_drained();
		release_bytes();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_BYTE:     regs.start_byte = val;
			CFG_END_BYTE:       regs.end_byte = val;
			CFG_BROADCAST_NODE: regs.broadcast_node = val;
			default: ;
		endcase
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	// Write all three registers back to back, optionally poking the spare index too.
	task automatic set_regs(input logic [7:0] sb, input logic [7:0] eb, input logic [7:0] bn,
			input bit poke_spare);
		write_reg(CFG_START_BYTE, sb, 1'b1);
		write_reg(CFG_END_BYTE, eb, 1'b1);
		write_reg(CFG_BROADCAST_NODE, bn, poke_spare);
		if (poke_spare)
			write_reg(CFG_IDX_SPARE, 8'($urandom), 1'b0);
		settings_used++;
	endtask

	function automatic logic [7:0] nonzero_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// Build a frame for the current settings, damage it at random, and send it.
	// A negative length request draws a mostly short length.
	task automatic send_frame(input int len_req);
		logic [7:0] f [$];
		logic [7:0] sum;
		logic [7:0] sid;
		int         len;
		int         tail;
		int         pick;
		int         cut;
		flaw_t      flaw;
		if (len_req >= 0)
			len = len_req;
		else if ($urandom_range(0, 29) == 0)
			len = $urandom_range(128, 255);
		else
			len = $urandom_range(0, 10);
		f.push_back(regs.start_byte);
		f.push_back(8'h00);
		do sid = 8'($urandom); while (sid == regs.broadcast_node);
		f.push_back(sid);
		repeat (3) f.push_back(8'($urandom));
		f.push_back($urandom_range(0, 1) ? nonzero_byte() : 8'h00);
		f.push_back(8'($urandom));
		f.push_back(8'(len));
		repeat (len) f.push_back(8'($urandom));
		sum = '0;
		for (int i = 0; i <= len + SUM_END - 1; i++)
			sum += f[i];
		f.push_back(sum);
		f.push_back(regs.end_byte);
		tail = $urandom_range(0, 3);
		pick = $urandom_range(0, 13);
		flaw = (pick > FLAW_NOISE) ? FLAW_NONE : flaw_t'(pick);
		case (flaw)
			FLAW_START: begin
				f[0] ^= nonzero_byte();
				if ($urandom_range(0, 1))
					f[2] = regs.broadcast_node;
			end
			FLAW_SECOND: begin
				f[1] = nonzero_byte();
				if ($urandom_range(0, 1))
					f[2] = regs.broadcast_node;
			end
			FLAW_SENDER: f[2] = regs.broadcast_node;
			FLAW_SUM:    f[HDR_LEN + len] ^= nonzero_byte();
			FLAW_END: begin
				f[END_OFS + len] ^= nonzero_byte();
				if ($urandom_range(0, 1))
					f[HDR_LEN + len] ^= nonzero_byte();
			end
			FLAW_CUT: begin
				// End the buffer anywhere up to the checksum byte.
				cut = $urandom_range(0, HDR_LEN + len);
				while (f.size() > cut + 1)
					void'(f.pop_back());
				tail = 0;
			end
			FLAW_NOISE: begin
				f = {};
				repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
				tail = 0;
			end
			default: ;
		endcase
		repeat (tail) f.push_back(8'($urandom));
		foreach (f[i])
			send_byte('{data_byte: f[i], frame_end: (i == f.size() - 1)}, 1'b0, ST_OK);
	endtask

	// Field-by-field compare of one returned beat against the oldest expectation.
	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("beat %0d %s: got %0h, want %0h", beat_no, name, got,
				want));
	endtask

	task automatic check_result(input out_t got);
		out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result beat %0h with nothing expected", got));
			return;
		end
		want = pending_results.pop_front();
		beat_no++;
		if (want.out_kind == KIND_VERDICT)
			verdict_cnt[want.status]++;
		else
			payload_cnt++;
		check_field("out_kind", got.out_kind, want.out_kind);
		check_field("payload_byte", got.payload_byte, want.payload_byte);
		check_field("status", got.status, want.status);
		check_field("sender_id", got.sender_id, want.sender_id);
		check_field("target_id", got.target_id, want.target_id);
		check_field("message_type", got.message_type, want.message_type);
		check_field("data_type", got.data_type, want.data_type);
		check_field("ack_wanted", got.ack_wanted, want.ack_wanted);
		check_field("sequence_count", got.sequence_count, want.sequence_count);
		check_field("payload_length", got.payload_length, want.payload_length);
	endtask

	// Result sink: draw a stall per beat, or take one long hold-off when asked.
	initial begin : result_sink
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_long_hold) begin
				hold         = LONG_HOLD;
				rx_long_hold = 1'b0;
			end else begin
				hold = rx_burst ? 0 : $urandom_range(0, 12);
			end
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_result(result_data);
		end
	end

	initial begin : stimulus
		int    phase_start;
		string tally;
		regs.start_byte     = 8'h00;
		regs.end_byte       = 8'h00;
		regs.broadcast_node = 8'hFF;
		clear_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at the reset register values.
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte('{data_byte: dir_rows[i].data, frame_end: dir_rows[i].last},
				dir_rows[i].pinned, dir_rows[i].verdict);
		wait_drained();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_regs(8'hFF, 8'hFF, 8'h00, 1'b0);
				1: set_regs(8'h00, 8'h00, 8'hFF, 1'b1);
				default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
			endcase
			phase_start = bytes_taken;
			if (ph == 0) begin
				// Longest payload once.
				tx_burst = 1'b0;
				rx_burst = 1'b0;
				send_frame(255);
			end
			if (ph == 2) begin
				// Back up the result side while bytes keep coming.
				rx_long_hold = 1'b1;
				tx_burst     = 1'b1;
				send_frame(60);
			end
			while (bytes_taken - phase_start < PHASE_BYTES) begin
				tx_burst = ($urandom_range(0, 4) == 0);
				rx_burst = ($urandom_range(0, 4) == 0);
				send_frame(-1);
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
			wait_drained();
		end

		repeat (5) @(posedge clk);
		tally = "";
		for (int s = ST_OK; s <= ST_TRUNCATED; s++)
			tally = $sformatf("%s %0d", tally, verdict_cnt[s]);
		$display("Covered %0d frame bytes under %0d register settings: %0d payload beats.",
			bytes_taken, settings_used, payload_cnt);
		$display("Verdicts ok/start/second/broadcast/end/checksum/truncated:%s", tally);
		if (mismatches == 0) begin
			$display("PASS packet_frame_decoder");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL packet_frame_decoder");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/pfd_pkg.sv
rtl/pfd_frame_parse.sv
rtl/packet_frame_decoder.sv
dv/tb.sv
